// ===== hdl/buddy_page_allocator_defines.svh =====
// assertion macros for the allocator top module
`ifndef BUDDY_PAGE_ALLOCATOR_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BPA_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define BPA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/bpa_pkg.sv =====
package bpa_pkg;

    localparam int FRAMES_DEF    = 65536;
    localparam int MAX_ORDER_DEF = 10;

    localparam logic [16:0] MEM_END_RESET = 17'd65536;
    localparam logic [16:0] USABLE_RESET  = 17'd65536;
    localparam logic [15:0] MIN_FRAME_RESET = 16'(32'h0010_0000 >> 12);
    localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

    localparam logic [2:0] FN_ALLOC       = 3'd0;
    localparam logic [2:0] FN_ALLOC_ALIGN = 3'd1;
    localparam logic [2:0] FN_ALLOC_BELOW = 3'd2;
    localparam logic [2:0] FN_FREE        = 3'd3;
    localparam logic [2:0] FN_FREE_SINGLE = 3'd4;
    localparam logic [2:0] FN_ADD_REGION  = 3'd5;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_ZERO       = 3'd1;
    localparam logic [2:0] ST_TOO_LARGE  = 3'd2;
    localparam logic [2:0] ST_NO_MEM     = 3'd3;
    localparam logic [2:0] ST_OUT_RANGE  = 3'd4;
    localparam logic [2:0] ST_BELOW_MIN  = 3'd5;
    localparam logic [2:0] ST_DOUBLE     = 3'd6;
    localparam logic [2:0] ST_MISALIGNED = 3'd7;

    localparam logic [1:0] CFG_MEM_END  = 2'd0;
    localparam logic [1:0] CFG_USABLE   = 2'd1;
    localparam logic [1:0] CFG_MIN_FREE = 2'd2;

    typedef struct packed {
        logic [2:0]  func;
        logic [16:0] page_count;
        logic [15:0] frame;
        logic [16:0] align_req;
        logic [16:0] limit_frame;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] alloc_frame;
        logic [16:0] free_count;
    } t_out_item;

    // per-field write enables of the frame memory
    typedef struct packed {
        logic tag;
        logic nx;
        logic pv;
    } t_wr_en;

endpackage

// ===== hdl/bpa_mem.sv =====
module bpa_mem #(
    parameter int FRAMES    = bpa_pkg::FRAMES_DEF,
    parameter int MAX_ORDER = bpa_pkg::MAX_ORDER_DEF
) (
    input  logic                         i_clk,
    input  logic [$clog2(FRAMES)-1:0]    i_wa,
    input  bpa_pkg::t_wr_en              i_we,
    input  logic [$clog2(MAX_ORDER+2)-1:0] i_wtag,
    input  logic [$clog2(FRAMES):0]      i_wnx,
    input  logic [$clog2(FRAMES):0]      i_wpv,
    input  logic [$clog2(FRAMES)-1:0]    i_ra,
    output logic [$clog2(MAX_ORDER+2)-1:0] o_rtag,
    output logic [$clog2(FRAMES):0]      o_rnx,
    output logic [$clog2(FRAMES):0]      o_rpv
);

    localparam int FW = $clog2(FRAMES);
    localparam int LW = FW + 1;
    localparam int TW = $clog2(MAX_ORDER + 2);

    // one entry per frame: order tag and the two list links, written per field
    logic [TW-1:0] r_tag_mem [FRAMES];
    logic [LW-1:0] r_nx_mem  [FRAMES];
    logic [LW-1:0] r_pv_mem  [FRAMES];

    logic [TW-1:0] r_rtag;
    logic [LW-1:0] r_rnx;
    logic [LW-1:0] r_rpv;

    always_ff @(posedge i_clk) begin
        if (i_we.tag) begin
            r_tag_mem[i_wa] <= i_wtag;
        end
        if (i_we.nx) begin
            r_nx_mem[i_wa] <= i_wnx;
        end
        if (i_we.pv) begin
            r_pv_mem[i_wa] <= i_wpv;
        end
        r_rtag <= r_tag_mem[i_ra];
        r_rnx  <= r_nx_mem[i_ra];
        r_rpv  <= r_pv_mem[i_ra];
    end

    assign o_rtag = r_rtag;
    assign o_rnx  = r_rnx;
    assign o_rpv  = r_rpv;

endmodule

// ===== hdl/buddy_page_allocator.sv =====
// buddy page allocator: one operation per item, exactly one result item per input item.
// input channel i_in_valid / o_in_stall carries func, page_count, frame, align_req
// and limit_frame; output channel o_out_valid / i_out_stall returns status, alloc_frame
// and the free page count after the operation.
// i_cfg_we / i_cfg_idx / i_cfg_data write mem_end_frame, the usable-page ceiling and min_free_frame.
// one item is worked on at a time by a sequencer around a frame memory with one write port
// and one registered read port that holds each frame's order tag and list links; an unlink
// reads the entry, relinks its neighbours or the list head and marks the frame not free; a
// push unlinks a listed frame, writes its entry and the list head and fixes the old head's
// back link. an alloc splits down to the wanted order, a free merges with free buddies, an
// alloc below a limit walks list entries, and adding a region pushes aligned blocks.
// after reset the order tags are cleared one frame a cycle (all FRAMES frames, 65536 by
// default) while o_in_stall stays high; configuration writes are taken during that pass.
// a finished result sits in an output register; the next item is accepted while it waits
// under i_out_stall, and the block holds at the end of that item until the slot is free.
`include "buddy_page_allocator_defines.svh"

module buddy_page_allocator #(
    parameter int FRAMES    = bpa_pkg::FRAMES_DEF,
    parameter int MAX_ORDER = bpa_pkg::MAX_ORDER_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  bpa_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output bpa_pkg::t_out_item o_out_item,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [16:0]        i_cfg_data
);

    localparam int FW = $clog2(FRAMES);
    localparam int LW = FW + 1;
    localparam int TW = $clog2(MAX_ORDER + 2);
    localparam int KW = TW;
    localparam int HW = $clog2(MAX_ORDER + 1);
    localparam int XW = ((FW > 17) ? FW : 17) + 1;
    localparam logic [XW-1:0] FRAMES_X = XW'(FRAMES);
    localparam logic [LW-1:0] NIL = LW'(FRAMES);
    localparam logic [TW-1:0] NOT_FREE = '1;
    localparam logic [KW-1:0] MAX_K = KW'(MAX_ORDER);

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_DEC, S_TAKE, S_CARVE, S_BH_HEAD, S_BH_CHK, S_BH_NEXT,
        S_REL_LOOP, S_REL_TAG, S_REL_MERGE, S_REL_END, S_REL_CNT, S_FREE_TAG,
        S_F4_CNT, S_REG, S_REG_CNT, S_LO_RD, S_LO_CHK, S_LO_W2, S_LO_W3,
        S_LI_A, S_LI_B, S_FIN
    } t_state;

    function automatic logic [16:0] cnt_add(logic [16:0] fp, logic [XW-1:0] x,
                                            logic [16:0] ceil);
        logic [XW-1:0] s;
        s = XW'(fp) + x;
        return (s > XW'(ceil)) ? ceil : s[16:0];
    endfunction

    function automatic logic [16:0] cnt_sub(logic [16:0] fp, logic [XW-1:0] x);
        return (XW'(fp) > x) ? 17'(XW'(fp) - x) : 17'd0;
    endfunction

    t_state r_state, n_state, r_ret, n_ret, r_ret_in, n_ret_in;
    bpa_pkg::t_in_item r_item, n_item;
    logic [KW-1:0] r_lv, n_lv, r_k, n_k, r_orig, n_orig, r_ulv, n_ulv;
    logic [4:0]    r_ak, n_ak;
    logic [FW-1:0] r_f, n_f, r_bud, n_bud, r_uf, n_uf, r_got, n_got;
    logic [XW-1:0] r_x, n_x, r_stop, n_stop;
    logic [LW-1:0] r_nx, n_nx, r_pv, n_pv;
    logic [2:0]    r_st, n_st;
    logic [16:0]   r_fp, n_fp;
    logic [FW:0]   r_clr, n_clr;
    bpa_pkg::t_out_item r_out, n_out;
    logic          r_ovalid, n_ovalid;
    logic [LW-1:0] r_head [MAX_ORDER+1];
    logic [16:0]   r_mem_end, r_usable;
    logic [15:0]   r_min;

    // memory port
    logic [FW-1:0]   mem_wa, mem_ra;
    bpa_pkg::t_wr_en mem_we;
    logic [TW-1:0]   mem_wtag, mem_rtag;
    logic [LW-1:0]   mem_wnx, mem_wpv, mem_rnx, mem_rpv;

    // list head port
    logic          hw_en;
    logic [HW-1:0] hw_idx, hd_idx;
    logic [LW-1:0] hw_val, hd_val;

    // decode and search helpers
    logic [XW-1:0] fr_x, cnt_x, min_x, end_x, want, pow_a, bud_x, g_x, e_x, left_x;
    logic [4:0]    ak;
    logic [KW-1:0] lv, tk, rk;
    logic          lv_ok, tk_ok, misal_fr, misal_got;
    logic [LW-1:0] tk_f;

    bpa_mem #(
        .FRAMES   (FRAMES),
        .MAX_ORDER(MAX_ORDER)
    ) u_mem (
        .i_clk (i_clk),
        .i_wa  (mem_wa),
        .i_we  (mem_we),
        .i_wtag(mem_wtag),
        .i_wnx (mem_wnx),
        .i_wpv (mem_wpv),
        .i_ra  (mem_ra),
        .o_rtag(mem_rtag),
        .o_rnx (mem_rnx),
        .o_rpv (mem_rpv)
    );

    assign fr_x  = XW'(r_item.frame);
    assign cnt_x = XW'(r_item.page_count);
    assign min_x = XW'(r_min);
    assign end_x = XW'(r_mem_end);

    assign hd_idx = (r_state == S_LI_A) ? r_ulv[HW-1:0] : r_k[HW-1:0];
    assign hd_val = r_head[hd_idx];

    always_comb begin
        ak = 5'd0;
        for (int k = 17; k >= 0; k--) begin
            if ((XW'(1) << k) >= XW'(r_item.align_req)) begin
                ak = 5'(k);
            end
        end
        pow_a = XW'(1) << ak;
        want = (r_item.func == bpa_pkg::FN_ALLOC_ALIGN && pow_a > cnt_x) ? pow_a : cnt_x;
        lv = '0;
        lv_ok = 1'b0;
        for (int k = MAX_ORDER; k >= 0; k--) begin
            if ((XW'(1) << k) >= want) begin
                lv = KW'(k);
                lv_ok = 1'b1;
            end
        end
        misal_fr  = (fr_x & ((XW'(1) << lv) - XW'(1))) != '0;
        misal_got = (XW'(r_got) & ((XW'(1) << r_ak) - XW'(1))) != '0;

        // lowest non-empty list at or above the wanted order
        tk = '0;
        tk_f = NIL;
        tk_ok = 1'b0;
        for (int k = MAX_ORDER; k >= 0; k--) begin
            if (KW'(k) >= r_lv && r_head[k] != NIL) begin
                tk = KW'(k);
                tk_f = r_head[k];
                tk_ok = 1'b1;
            end
        end

        // largest aligned block that still fits the region
        left_x = r_stop - r_x;
        rk = '0;
        for (int k = 1; k <= MAX_ORDER; k++) begin
            if (((r_x & ((XW'(1) << k) - XW'(1))) == '0) && (left_x >= (XW'(1) << k))) begin
                rk = KW'(k);
            end
        end

        e_x = fr_x + cnt_x;
        if (e_x > FRAMES_X) begin
            e_x = FRAMES_X;
        end
        if (e_x > end_x) begin
            e_x = end_x;
        end

        bud_x = XW'(r_f) ^ (XW'(1) << r_k);
        g_x = XW'(r_f) + (XW'(1) << (r_k - KW'(1)));
    end

    always_comb begin
        n_state = r_state;
        n_ret = r_ret;
        n_ret_in = r_ret_in;
        n_item = r_item;
        n_lv = r_lv;
        n_k = r_k;
        n_orig = r_orig;
        n_ulv = r_ulv;
        n_ak = r_ak;
        n_f = r_f;
        n_bud = r_bud;
        n_uf = r_uf;
        n_got = r_got;
        n_x = r_x;
        n_stop = r_stop;
        n_nx = r_nx;
        n_pv = r_pv;
        n_st = r_st;
        n_fp = r_fp;
        n_clr = r_clr;
        n_out = r_out;
        n_ovalid = r_ovalid && i_out_stall;
        mem_wa = '0;
        mem_ra = '0;
        mem_we = '0;
        mem_wtag = NOT_FREE;
        mem_wnx = NIL;
        mem_wpv = NIL;
        hw_en = 1'b0;
        hw_idx = '0;
        hw_val = NIL;

        case (r_state)
            S_CLR: begin
                mem_wa = r_clr[FW-1:0];
                mem_we.tag = 1'b1;
                n_clr = r_clr + 1'b1;
                if (r_clr == (FW+1)'(FRAMES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item = i_in_item;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_st = bpa_pkg::ST_OK;
                n_got = '0;
                n_lv = lv;
                n_k = lv;
                n_orig = lv;
                n_ak = ak;
                n_state = S_FIN;
                case (r_item.func)
                    bpa_pkg::FN_ALLOC, bpa_pkg::FN_ALLOC_ALIGN, bpa_pkg::FN_ALLOC_BELOW: begin
                        if (cnt_x == '0) begin
                            n_st = bpa_pkg::ST_ZERO;
                        end else if (!lv_ok) begin
                            n_st = bpa_pkg::ST_TOO_LARGE;
                        end else if (r_item.func == bpa_pkg::FN_ALLOC_BELOW) begin
                            n_state = S_BH_HEAD;
                        end else begin
                            n_state = S_TAKE;
                        end
                    end
                    bpa_pkg::FN_FREE: begin
                        if (cnt_x == '0) begin
                            n_st = bpa_pkg::ST_ZERO;
                        end else if (fr_x >= end_x || fr_x >= FRAMES_X) begin
                            n_st = bpa_pkg::ST_OUT_RANGE;
                        end else if (fr_x < min_x) begin
                            n_st = bpa_pkg::ST_BELOW_MIN;
                        end else if (!lv_ok) begin
                            n_st = bpa_pkg::ST_TOO_LARGE;
                        end else if (misal_fr) begin
                            n_st = bpa_pkg::ST_MISALIGNED;
                        end else begin
                            mem_ra = FW'(fr_x);
                            n_state = S_FREE_TAG;
                        end
                    end
                    bpa_pkg::FN_FREE_SINGLE: begin
                        if (fr_x >= end_x || fr_x >= FRAMES_X) begin
                            n_st = bpa_pkg::ST_OUT_RANGE;
                        end else if (fr_x < min_x) begin
                            n_st = bpa_pkg::ST_BELOW_MIN;
                        end else begin
                            mem_ra = FW'(fr_x);
                            n_state = S_FREE_TAG;
                        end
                    end
                    bpa_pkg::FN_ADD_REGION: begin
                        n_x = (fr_x < min_x) ? min_x : fr_x;
                        n_stop = e_x;
                        n_state = S_REG;
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end
            S_TAKE: begin
                if (!tk_ok) begin
                    n_st = bpa_pkg::ST_NO_MEM;
                    n_state = S_FIN;
                end else begin
                    n_k = tk;
                    n_f = FW'(tk_f);
                    n_got = FW'(tk_f);
                    n_uf = FW'(tk_f);
                    n_ret = S_CARVE;
                    n_state = S_LO_RD;
                end
            end
            S_CARVE: begin
                if (r_k > r_lv) begin
                    n_k = r_k - KW'(1);
                    if (g_x < FRAMES_X) begin
                        n_uf = FW'(g_x);
                        n_ulv = r_k - KW'(1);
                        n_ret = S_LI_A;
                        n_ret_in = S_CARVE;
                        n_state = S_LO_RD;
                    end
                end else begin
                    n_fp = cnt_sub(r_fp, XW'(1) << r_lv);
                    n_state = S_FIN;
                    if (r_item.func == bpa_pkg::FN_ALLOC_ALIGN && misal_got) begin
                        // hand the block back when it is not below min_free_frame, then report the miss
                        n_st = bpa_pkg::ST_MISALIGNED;
                        n_f = r_got;
                        n_k = r_lv;
                        n_orig = r_lv;
                        if (XW'(r_got) >= min_x) begin
                            n_state = S_REL_LOOP;
                        end
                    end
                end
            end
            S_BH_HEAD: begin
                if (r_k > MAX_K) begin
                    n_st = bpa_pkg::ST_NO_MEM;
                    n_state = S_FIN;
                end else begin
                    n_x = XW'(hd_val);
                    n_state = S_BH_CHK;
                end
            end
            S_BH_CHK: begin
                if (r_x >= FRAMES_X) begin
                    n_k = r_k + KW'(1);
                    n_state = S_BH_HEAD;
                end else if (r_x >= min_x &&
                             r_x + (XW'(1) << r_lv) <= XW'(r_item.limit_frame)) begin
                    n_got = FW'(r_x);
                    n_f = FW'(r_x);
                    n_uf = FW'(r_x);
                    n_ret = S_CARVE;
                    n_state = S_LO_RD;
                end else begin
                    mem_ra = FW'(r_x);
                    n_state = S_BH_NEXT;
                end
            end
            S_BH_NEXT: begin
                n_x = XW'(mem_rnx);
                n_state = S_BH_CHK;
            end
            S_REL_LOOP: begin
                n_state = S_REL_END;
                if (r_k < MAX_K) begin
                    if (!(bud_x < min_x || bud_x >= end_x || bud_x >= FRAMES_X)) begin
                        mem_ra = FW'(bud_x);
                        n_bud = FW'(bud_x);
                        n_state = S_REL_TAG;
                    end
                end
            end
            S_REL_TAG: begin
                if (mem_rtag != TW'(r_k)) begin
                    n_state = S_REL_END;
                end else begin
                    n_uf = r_bud;
                    n_ret = S_REL_MERGE;
                    n_state = S_LO_RD;
                end
            end
            S_REL_MERGE: begin
                if (r_bud < r_f) begin
                    n_f = r_bud;
                end
                n_k = r_k + KW'(1);
                n_state = S_REL_LOOP;
            end
            S_REL_END: begin
                n_uf = r_f;
                n_ulv = r_k;
                n_ret = S_LI_A;
                n_ret_in = S_REL_CNT;
                n_state = S_LO_RD;
            end
            S_REL_CNT: begin
                // the count grows by the freed size, not the merged one
                n_fp = cnt_add(r_fp, XW'(1) << r_orig, r_usable);
                n_state = S_FIN;
            end
            S_FREE_TAG: begin
                if (mem_rtag != NOT_FREE) begin
                    n_st = bpa_pkg::ST_DOUBLE;
                    n_state = S_FIN;
                end else if (r_item.func == bpa_pkg::FN_FREE) begin
                    n_f = FW'(fr_x);
                    n_state = S_REL_LOOP;
                end else begin
                    n_uf = FW'(fr_x);
                    n_ulv = '0;
                    n_ret = S_LI_A;
                    n_ret_in = S_F4_CNT;
                    n_state = S_LO_RD;
                end
            end
            S_F4_CNT: begin
                n_fp = cnt_add(r_fp, XW'(1), r_usable);
                n_state = S_FIN;
            end
            S_REG: begin
                if (r_x < r_stop) begin
                    n_uf = FW'(r_x);
                    n_ulv = rk;
                    n_k = rk;
                    n_ret = S_LI_A;
                    n_ret_in = S_REG_CNT;
                    n_state = S_LO_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_REG_CNT: begin
                n_fp = cnt_add(r_fp, XW'(1) << r_k, bpa_pkg::COUNT_MAX);
                n_x = r_x + (XW'(1) << r_k);
                n_state = S_REG;
            end
            // unlink r_uf if it heads a free block, then go to r_ret
            S_LO_RD: begin
                mem_ra = r_uf;
                n_state = S_LO_CHK;
            end
            S_LO_CHK: begin
                if (mem_rtag > TW'(MAX_ORDER)) begin
                    n_state = r_ret;
                end else begin
                    n_nx = mem_rnx;
                    n_pv = mem_rpv;
                    if (mem_rpv < NIL) begin
                        mem_wa = FW'(mem_rpv);
                        mem_we.nx = 1'b1;
                        mem_wnx = mem_rnx;
                    end else begin
                        hw_en = 1'b1;
                        hw_idx = mem_rtag[HW-1:0];
                        hw_val = mem_rnx;
                    end
                    n_state = S_LO_W2;
                end
            end
            S_LO_W2: begin
                if (r_nx < NIL) begin
                    mem_wa = FW'(r_nx);
                    mem_we.pv = 1'b1;
                    mem_wpv = r_pv;
                end
                n_state = S_LO_W3;
            end
            S_LO_W3: begin
                mem_wa = r_uf;
                mem_we.tag = 1'b1;
                mem_wtag = NOT_FREE;
                n_state = r_ret;
            end
            // push r_uf on list r_ulv, then go to r_ret_in
            S_LI_A: begin
                mem_wa = r_uf;
                mem_we = '1;
                mem_wtag = TW'(r_ulv);
                mem_wnx = hd_val;
                mem_wpv = NIL;
                hw_en = 1'b1;
                hw_idx = r_ulv[HW-1:0];
                hw_val = LW'(r_uf);
                n_nx = hd_val;
                n_state = S_LI_B;
            end
            S_LI_B: begin
                if (r_nx < NIL) begin
                    mem_wa = FW'(r_nx);
                    mem_we.pv = 1'b1;
                    mem_wpv = LW'(r_uf);
                end
                n_state = r_ret_in;
            end
            S_FIN: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_out.status = r_st;
                    n_out.alloc_frame = (r_st == bpa_pkg::ST_OK) ? 16'(r_got) : 16'd0;
                    n_out.free_count = r_fp;
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_ret <= S_IDLE;
            r_ret_in <= S_IDLE;
            r_clr <= '0;
            r_fp <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret <= n_ret;
            r_ret_in <= n_ret_in;
            r_clr <= n_clr;
            r_fp <= n_fp;
            r_ovalid <= n_ovalid;
        end
        r_item <= n_item;
        r_lv <= n_lv;
        r_k <= n_k;
        r_orig <= n_orig;
        r_ulv <= n_ulv;
        r_ak <= n_ak;
        r_f <= n_f;
        r_bud <= n_bud;
        r_uf <= n_uf;
        r_got <= n_got;
        r_x <= n_x;
        r_stop <= n_stop;
        r_nx <= n_nx;
        r_pv <= n_pv;
        r_st <= n_st;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= MAX_ORDER; k++) begin
                r_head[k] <= NIL;
            end
        end else if (hw_en) begin
            r_head[hw_idx] <= hw_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_end <= bpa_pkg::MEM_END_RESET;
            r_usable <= bpa_pkg::USABLE_RESET;
            r_min <= bpa_pkg::MIN_FRAME_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bpa_pkg::CFG_MEM_END:  r_mem_end <= i_cfg_data;
                bpa_pkg::CFG_USABLE:   r_usable <= i_cfg_data;
                bpa_pkg::CFG_MIN_FREE: r_min <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_item = r_out;

    `BPA_ASSERT_NOW(a_wr_range, mem_we.tag || mem_we.nx || mem_we.pv, (FW+1)'(mem_wa) < (FW+1)'(FRAMES), "frame memory written out of range")
    `BPA_ASSERT_NOW(a_idle_quiet, r_state == S_IDLE, !(mem_we.tag || mem_we.nx || mem_we.pv) && !hw_en, "state written while idle")
    `BPA_ASSERT_NOW(a_fail_no_frame, o_out_valid && o_out_item.status != bpa_pkg::ST_OK, o_out_item.alloc_frame == 16'd0, "failed result carries a frame")
    `BPA_ASSERT_NEXT(a_accept_dec, i_in_valid && !o_in_stall, r_state == S_DEC, "accepted item not decoded")

endmodule

// ===== tb/tb.sv =====
module tb;

    localparam int FR        = 65536;
    localparam int MAXO      = 10;
    localparam int UNLISTED  = 255;
    localparam int STALL_MAX = 400000;
    localparam int HOLD_LEN  = 400;

    typedef struct {
        int base;
        int pages;
    } t_block;

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    logic        in_stall;
    bpa_pkg::t_in_item  in_item;
    logic        out_valid;
    logic        out_stall;
    bpa_pkg::t_out_item out_item;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [16:0] cfg_data;

    buddy_page_allocator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    // allocator shadow state
    int nxt_a[FR];
    int prv_a[FR];
    int ord_a[FR];
    int head_a[MAXO+1];
    int pages;
    int end_frame;
    int usable;
    int min_frame;

    bpa_pkg::t_in_item  pend_q[$];
    bpa_pkg::t_out_item result_q[$];
    t_block    held_blocks[$];

    int  send_idle_pct;
    int  recv_idle_pct;
    bit  send_pause;
    bit  hold_req;
    bit  hold_done;
    int  hold_cnt;
    int  idle_cycles;
    int  n_items;
    int  n_results;
    int  n_alloc_ok;
    int  n_free_ok;
    int  n_bad;
    bit  busy;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic void unlink(int f);
        int lv, nx, pv;
        lv = ord_a[f];
        if (lv > MAXO) return;
        nx = nxt_a[f];
        pv = prv_a[f];
        if (pv < FR) nxt_a[pv] = nx; else head_a[lv] = nx;
        if (nx < FR) prv_a[nx] = pv;
        ord_a[f] = UNLISTED;
    endfunction

    function automatic void push_block(int f, int lv);
        int h;
        unlink(f);
        h = head_a[lv];
        nxt_a[f] = h;
        prv_a[f] = FR;
        if (h < FR) prv_a[h] = f;
        head_a[lv] = f;
        ord_a[f] = lv;
    endfunction

    function automatic void pages_add(int x, int ceil);
        pages += x;
        if (pages > ceil) pages = ceil;
    endfunction

    function automatic void pages_sub(int x);
        pages = (pages > x) ? pages - x : 0;
    endfunction

    function automatic int order_of(int n);
        int k;
        k = 0;
        while (k <= MAXO && (1 << k) < n) k++;
        return (k > MAXO) ? -1 : k;
    endfunction

    function automatic void split_down(int f, int from, int to);
        int g;
        while (from > to) begin
            from--;
            g = f + (1 << from);
            if (g < FR) push_block(g, from);
        end
    endfunction

    function automatic bit grab(int lv, output int got);
        int f;
        got = 0;
        for (int k = lv; k <= MAXO; k++) begin
            f = head_a[k];
            if (f < FR) begin
                unlink(f);
                split_down(f, k, lv);
                pages_sub(1 << lv);
                got = f;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit grab_below(int lv, int lim, output int got);
        int x, steps;
        got = 0;
        for (int k = lv; k <= MAXO; k++) begin
            x = head_a[k];
            steps = 0;
            while (x < FR && steps < FR) begin
                if (x >= min_frame && x + (1 << lv) <= lim) begin
                    unlink(x);
                    split_down(x, k, lv);
                    pages_sub(1 << lv);
                    got = x;
                    return 1'b1;
                end
                x = nxt_a[x];
                steps++;
            end
        end
        return 1'b0;
    endfunction

    function automatic void merge_free(int f, int lv);
        int orig, bud;
        orig = lv;
        if (f < min_frame || f >= FR) return;
        while (lv < MAXO) begin
            bud = f ^ (1 << lv);
            if (bud < min_frame || bud >= end_frame || bud >= FR) break;
            if (ord_a[bud] != lv) break;
            unlink(bud);
            if (bud < f) f = bud;
            lv++;
        end
        push_block(f, lv);
        pages_add(1 << orig, usable);
    endfunction

    function automatic void region_add(int x, int cnt);
        int stop, left, k;
        stop = x + cnt;
        if (stop > FR) stop = FR;
        if (stop > end_frame) stop = end_frame;
        if (x < min_frame) x = min_frame;
        while (x < stop) begin
            left = stop - x;
            k = MAXO;
            while (k > 0 && !((x & ((1 << k) - 1)) == 0 && left >= (1 << k))) k--;
            push_block(x, k);
            pages_add(1 << k, int'(bpa_pkg::COUNT_MAX));
            x += 1 << k;
        end
    endfunction

    function automatic bpa_pkg::t_out_item predict_result(bpa_pkg::t_in_item it);
        bpa_pkg::t_out_item r;
        int cnt, fr, al, lim, st, got, lv, want, a;
        cnt = it.page_count;
        fr  = it.frame;
        al  = it.align_req;
        lim = it.limit_frame;
        st  = bpa_pkg::ST_OK;
        got = 0;
        if (it.func == bpa_pkg::FN_ALLOC || it.func == bpa_pkg::FN_ALLOC_ALIGN
                || it.func == bpa_pkg::FN_ALLOC_BELOW) begin
            want = cnt;
            a = 1;
            if (it.func == bpa_pkg::FN_ALLOC_ALIGN) begin
                while (a < al) a <<= 1;
                if (a > want) want = a;
            end
            lv = order_of(want);
            if (cnt == 0) st = bpa_pkg::ST_ZERO;
            else if (lv < 0) st = bpa_pkg::ST_TOO_LARGE;
            else if (it.func == bpa_pkg::FN_ALLOC_BELOW)
                st = grab_below(lv, lim, got) ? bpa_pkg::ST_OK : bpa_pkg::ST_NO_MEM;
            else if (!grab(lv, got)) st = bpa_pkg::ST_NO_MEM;
            else if (it.func == bpa_pkg::FN_ALLOC_ALIGN && (got & (a - 1)) != 0) begin
                merge_free(got, lv);
                st = bpa_pkg::ST_MISALIGNED;
            end
            if (st != bpa_pkg::ST_OK) got = 0;
            else begin
                held_blocks.push_back('{got, 1 << lv});
                n_alloc_ok++;
            end
        end else if (it.func == bpa_pkg::FN_FREE) begin
            lv = order_of(cnt);
            if (cnt == 0) st = bpa_pkg::ST_ZERO;
            else if (fr >= end_frame) st = bpa_pkg::ST_OUT_RANGE;
            else if (fr < min_frame) st = bpa_pkg::ST_BELOW_MIN;
            else if (lv < 0) st = bpa_pkg::ST_TOO_LARGE;
            else if ((fr & ((1 << lv) - 1)) != 0) st = bpa_pkg::ST_MISALIGNED;
            else if (ord_a[fr] != UNLISTED) st = bpa_pkg::ST_DOUBLE;
            else begin
                merge_free(fr, lv);
                n_free_ok++;
            end
        end else if (it.func == bpa_pkg::FN_FREE_SINGLE) begin
            if (fr >= end_frame) st = bpa_pkg::ST_OUT_RANGE;
            else if (fr < min_frame) st = bpa_pkg::ST_BELOW_MIN;
            else if (ord_a[fr] != UNLISTED) st = bpa_pkg::ST_DOUBLE;
            else begin
                push_block(fr, 0);
                pages_add(1, usable);
                n_free_ok++;
            end
        end else if (it.func == bpa_pkg::FN_ADD_REGION) begin
            region_add(fr, cnt);
        end
        r.status      = st[2:0];
        r.alloc_frame = got[15:0];
        r.free_count  = pages[16:0];
        return r;
    endfunction

    // driver: holds an item until it is taken, then predicts its result
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            busy = in_valid;
            if (in_valid && !in_stall) begin
                result_q.push_back(predict_result(in_item));
                n_items++;
                busy = 1'b0;
            end
            if (!busy) begin
                if (pend_q.size() > 0 && !send_pause && $urandom_range(99) >= send_idle_pct) begin
                    in_item  <= pend_q.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stall
    always @(posedge i_clk) begin
        bpa_pkg::t_out_item w;
        if (i_rst_n && out_valid && !out_stall) begin
            n_results++;
            if (result_q.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("unexpected result item: %p", out_item);
            end else begin
                w = result_q.pop_front();
                if (w.status !== out_item.status || w.alloc_frame !== out_item.alloc_frame
                        || w.free_count !== out_item.free_count) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("mismatch: exp st=%0d frame=%0d count=%0d got st=%0d frame=%0d count=%0d",
                                 w.status, w.alloc_frame, w.free_count, out_item.status,
                                 out_item.alloc_frame, out_item.free_count);
                end
            end
        end
        if (hold_req && !hold_done) begin
            out_stall <= 1'b1;
            hold_cnt++;
            if (hold_cnt >= HOLD_LEN) hold_done <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_MAX) begin
            $display("watchdog: no progress for %0d cycles", idle_cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic bpa_pkg::t_in_item mk(logic [2:0] f, int cnt, int fr, int al, int lim);
        bpa_pkg::t_in_item it;
        it.func        = f;
        it.page_count  = cnt[16:0];
        it.frame       = fr[15:0];
        it.align_req   = al[16:0];
        it.limit_frame = lim[16:0];
        return it;
    endfunction

    task automatic cfg_write(input logic [1:0] idx, input int val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val[16:0];
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == bpa_pkg::CFG_MEM_END) end_frame = val & 17'h1FFFF;
        else if (idx == bpa_pkg::CFG_USABLE) usable = val & 17'h1FFFF;
        else if (idx == bpa_pkg::CFG_MIN_FREE) min_frame = val & 16'hFFFF;
    endtask

    task automatic drain;
        while (pend_q.size() > 0 || in_valid || result_q.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic bpa_pkg::t_in_item random_op();
        int r, cnt, idx, top;
        t_block b;
        r = $urandom_range(99);
        top = (end_frame > FR) ? FR : end_frame;
        if (r < 40) begin
            r = $urandom_range(99);
            cnt = (r < 70) ? $urandom_range(1, 8) :
                  (r < 95) ? $urandom_range(1, 128) : $urandom_range(1, 1100);
            return mk(3'($urandom_range(bpa_pkg::FN_ALLOC_BELOW)), cnt, $urandom_range(65535),
                      (r < 50) ? $urandom_range(0, 64) : $urandom_range(0, 2048),
                      $urandom_range(0, top + 64));
        end else if (r < 75 && held_blocks.size() > 0) begin
            idx = $urandom_range(held_blocks.size() - 1);
            b = held_blocks[idx];
            held_blocks.delete(idx);
            if (b.pages == 1 && $urandom_range(9) < 3)
                return mk(bpa_pkg::FN_FREE_SINGLE, $urandom_range(65536), b.base, 0, 0);
            return mk(bpa_pkg::FN_FREE, $urandom_range(b.pages / 2 + 1, b.pages), b.base,
                      $urandom_range(65536), $urandom_range(65536));
        end else if (r < 85) begin
            return mk(bpa_pkg::FN_ADD_REGION, $urandom_range(1, 600),
                      $urandom_range(0, (top > 0) ? top - 1 : 0), 0, 0);
        end
        return mk(3'($urandom_range(7)), $urandom_range(65536), $urandom_range(65535),
                  $urandom_range(65536), $urandom_range(65536));
    endfunction

    task automatic run_random(input int n);
        for (int i = 0; i < n; i += 25) begin
            while (pend_q.size() > 0) @(posedge i_clk);
            for (int j = 0; j < 25; j++) pend_q.push_back(random_op());
        end
    endtask

    initial begin
        for (int i = 0; i < FR; i++) ord_a[i] = UNLISTED;
        for (int k = 0; k <= MAXO; k++) head_a[k] = FR;
        pages = 0;
        end_frame = 65536;
        usable = 65536;
        min_frame = 256;
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = bpa_pkg::CFG_MEM_END;
        cfg_data = '0;
        send_pause = 1'b0;
        hold_req = 1'b0;
        hold_done = 1'b0;
        hold_cnt = 0;
        idle_cycles = 0;
        send_idle_pct = 10;
        recv_idle_pct = 80;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default-like settings, taken while the tag clearing pass runs
        cfg_write(bpa_pkg::CFG_MEM_END, 65536);
        cfg_write(bpa_pkg::CFG_USABLE, 65536);
        cfg_write(bpa_pkg::CFG_MIN_FREE, 256);

        pend_q.push_back(mk(bpa_pkg::FN_ALLOC, 1, 0, 0, 0));
        pend_q.push_back(mk(bpa_pkg::FN_ALLOC, 0, 0, 0, 0));
        pend_q.push_back(mk(bpa_pkg::FN_ADD_REGION, 0, 300, 0, 0));
        pend_q.push_back(mk(bpa_pkg::FN_ADD_REGION, 65536, 0, 0, 0));
        pend_q.push_back(mk(bpa_pkg::FN_ALLOC, 1, 65535, 65536, 65536));
        pend_q.push_back(mk(bpa_pkg::FN_ALLOC, 1024, 0, 0, 0));
        pend_q.push_back(mk(bpa_pkg::FN_ALLOC, 1025, 0, 0, 0));
        pend_q.push_back(mk(bpa_pkg::FN_ALLOC, 65536, 0, 0, 0));
        pend_q.push_back(mk(bpa_pkg::FN_ALLOC_ALIGN, 1, 0, 0, 0));
        pend_q.push_back(mk(bpa_pkg::FN_ALLOC_ALIGN, 3, 0, 512, 0));
        pend_q.push_back(mk(bpa_pkg::FN_ALLOC_ALIGN, 1, 0, 65536, 0));
        pend_q.push_back(mk(bpa_pkg::FN_ALLOC_BELOW, 4, 0, 0, 0));
        pend_q.push_back(mk(bpa_pkg::FN_ALLOC_BELOW, 4, 0, 0, 300));
        pend_q.push_back(mk(bpa_pkg::FN_ALLOC_BELOW, 2, 0, 0, 65536));
        pend_q.push_back(mk(bpa_pkg::FN_FREE, 0, 512, 0, 0));
        pend_q.push_back(mk(bpa_pkg::FN_FREE, 1, 10, 0, 0));
        pend_q.push_back(mk(bpa_pkg::FN_FREE, 2048, 1024, 0, 0));
        pend_q.push_back(mk(bpa_pkg::FN_FREE, 2, 257, 0, 0));
        pend_q.push_back(mk(bpa_pkg::FN_FREE, 1, 65535, 0, 0));
        pend_q.push_back(mk(bpa_pkg::FN_FREE, 1, 65535, 0, 0));
        pend_q.push_back(mk(bpa_pkg::FN_FREE_SINGLE, 0, 5000, 0, 0));
        pend_q.push_back(mk(bpa_pkg::FN_FREE_SINGLE, 0, 5000, 0, 0));
        pend_q.push_back(mk(3'd6, 65536, 65535, 65536, 65536));
        pend_q.push_back(mk(3'd7, 0, 0, 0, 0));
        run_random(550);
        drain();

        // small memory, no floor; long receiver hold while items keep coming
        cfg_write(bpa_pkg::CFG_MEM_END, 4096);
        cfg_write(bpa_pkg::CFG_USABLE, 3000);
        cfg_write(bpa_pkg::CFG_MIN_FREE, 0);
        send_idle_pct = 80;
        recv_idle_pct = 10;
        pend_q.push_back(mk(bpa_pkg::FN_FREE, 1, 4096, 0, 0));
        pend_q.push_back(mk(bpa_pkg::FN_ADD_REGION, 4096, 0, 0, 0));
        for (int j = 0; j < 20; j++)
            pend_q.push_back(mk(bpa_pkg::FN_ALLOC, $urandom_range(1, 4), 0, 0, 0));
        @(posedge i_clk);
        send_idle_pct = 0;
        hold_req <= 1'b1;
        while (!hold_done) @(posedge i_clk);
        hold_req <= 1'b0;
        send_idle_pct = 80;
        run_random(580);
        drain();

        // extremes: one frame of range, zero ceiling, top floor
        cfg_write(bpa_pkg::CFG_MEM_END, 1);
        cfg_write(bpa_pkg::CFG_USABLE, 0);
        cfg_write(bpa_pkg::CFG_MIN_FREE, 65535);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        pend_q.push_back(mk(bpa_pkg::FN_FREE, 1, 0, 0, 0));
        pend_q.push_back(mk(bpa_pkg::FN_ADD_REGION, 65536, 0, 0, 0));
        run_random(25);
        drain();

        cfg_write(bpa_pkg::CFG_MEM_END, 65536);
        cfg_write(bpa_pkg::CFG_USABLE, 65536);
        cfg_write(bpa_pkg::CFG_MIN_FREE, 512);
        pend_q.push_back(mk(bpa_pkg::FN_ADD_REGION, 8192, 512, 0, 0));
        run_random(575);
        drain();

        $display("ran %0d items, checked %0d results: %0d allocs and %0d frees succeeded",
                 n_items, n_results, n_alloc_ok, n_free_ok);
        $display("covered four register settings, both idling mixes and a %0d-cycle hold",
                 HOLD_LEN);
        if (n_bad == 0 && result_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches, %0d results missing", n_bad, result_q.size());
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
